FILE: rtl/resident_slot_pool_no_evict_macros.svh
// Assertion macros used by the checker file of the slot pool.
`ifndef RESIDENT_SLOT_POOL_NO_EVICT_MACROS_SVH
`define RESIDENT_SLOT_POOL_NO_EVICT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define RSPOOL_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rspool: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define RSPOOL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rspool: next-cycle check failed");

`endif

FILE: rtl/rspool_pkg.sv
`timescale 1ns / 1ps

package rspool_pkg;

   // Width of the scan counters; covers every count up to 127 entries.
   localparam int SCAN_W = 7;

   localparam logic OP_ENSURE = 1'b0;
   localparam logic OP_RESET  = 1'b1;

   // Word index of the row limit register (paddr bit 2).
   localparam logic CSR_ROW_LIMIT = 1'b0;

   localparam logic [8:0] ROW_LIMIT_RESET = 9'd238;

   typedef enum logic [2:0] {
      KIND_IGNORED   = 3'd0,
      KIND_HIT       = 3'd1,
      KIND_LOAD      = 3'd2,
      KIND_OVERFLOW  = 3'd3,
      KIND_BLANK_ROW = 3'd4,
      KIND_SUMMARY   = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SLOT_SCAN,
      ST_REC_SCAN,
      ST_DUMP,
      ST_SUMMARY
   } state_type;

   typedef struct packed {
      logic              start;
      logic              walk;
      logic [SCAN_W-1:0] limit;
      logic [8:0]        key;
   } scan_cmd_type;

   typedef struct packed {
      logic              rd_en;
      logic [SCAN_W-1:0] rd_addr;
      logic              chk_vld;
      logic              done;
      logic              hit;
      logic [SCAN_W-1:0] index;
   } scan_stat_type;

endpackage

FILE: rtl/rspool_ram.sv
`timescale 1ns / 1ps

module rspool_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 16
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/rspool_scan.sv
`timescale 1ns / 1ps

// Shared scan unit: walks entries 0 .. limit-1 of a registered-read memory,
// one entry a cycle, and, unless in walk mode, compares each against a key with one comparator.
module rspool_scan (
   input  logic                     clock,
   input  logic                     reset,
   input  rspool_pkg::scan_cmd_type cmd,
   input  logic [8:0]               rd_data,
   output rspool_pkg::scan_stat_type stat
);

   localparam int SW = rspool_pkg::SCAN_W;

   logic          active_ff, active_in;
   logic          walk_ff, walk_in;
   logic [SW-1:0] limit_ff, limit_in;
   logic [8:0]    key_ff, key_in;
   logic [SW-1:0] issue_ff, issue_in;
   logic          chk_vld_ff, chk_vld_in;
   logic [SW-1:0] chk_idx_ff, chk_idx_in;
   logic          issue_more;
   logic          match;

   always_comb begin
      issue_more = active_ff && (issue_ff < limit_ff);
      match      = active_ff && chk_vld_ff && !walk_ff && (rd_data == key_ff);

      stat.rd_en   = issue_more;
      stat.rd_addr = issue_ff;
      stat.chk_vld = active_ff && chk_vld_ff;
      stat.done    = active_ff && (match || !issue_more);
      stat.hit     = match;
      stat.index   = chk_idx_ff;

      active_in  = active_ff;
      walk_in    = walk_ff;
      limit_in   = limit_ff;
      key_in     = key_ff;
      issue_in   = issue_ff;
      chk_vld_in = chk_vld_ff;
      chk_idx_in = chk_idx_ff;

      if (cmd.start) begin
         active_in  = 1'b1;
         walk_in    = cmd.walk;
         limit_in   = cmd.limit;
         key_in     = cmd.key;
         issue_in   = '0;
         chk_vld_in = 1'b0;
      end else if (stat.done) begin
         active_in  = 1'b0;
         chk_vld_in = 1'b0;
      end else if (active_ff) begin
         // Data for the entry issued now arrives next cycle.
         chk_vld_in = 1'b1;
         chk_idx_in = issue_ff;
         issue_in   = issue_ff + SW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 1'b0;
         chk_vld_ff <= 1'b0;
      end else begin
         active_ff  <= active_in;
         chk_vld_ff <= chk_vld_in;
      end
      walk_ff    <= walk_in;
      limit_ff   <= limit_in;
      key_ff     <= key_in;
      issue_ff   <= issue_in;
      chk_idx_ff <= chk_idx_in;
   end

endmodule

FILE: rtl/resident_slot_pool_no_evict.sv
`timescale 1ns / 1ps

// Resident slot pool without eviction. A command is taken when start is high
// and busy is low; each result beat appears on the rsp_ ports for exactly one
// cycle with rsp_strobe high, and the receiver cannot stall it, so it must take
// every beat as it comes. An ignored ensure returns its single beat in the
// cycle after acceptance and leaves busy low. Any other ensure keeps busy high
// while one comparator scans first the slot owners and then the record list,
// one entry a cycle out of registered-read memories; a hit in either list ends
// that scan early. Its beat appears in the same cycle that busy falls. A
// generation reset keeps busy high and sends one blank-row beat per recorded
// row on consecutive cycles, then the summary beat marked last, which shows
// the counters of the ending generation. Slots fill in order and are only
// freed all at once, so the lowest free slot is always the fill count and no
// clearing pass is needed after reset. The user must see that the row limit
// register is written over the APB port only while the block is idle; the
// block itself does not enforce this.
module resident_slot_pool_no_evict #(
   parameter int SLOT_COUNT   = 16,
   parameter int RECORD_DEPTH = 48,
   parameter int SET_COUNT    = 256
) (
   input  logic               clock,
   input  logic               reset,
   // command channel
   input  logic               start,
   output logic               busy,
   input  logic               req_operation,
   input  logic signed [9:0]  req_row,
   input  logic signed [8:0]  req_set_index,
   input  logic               req_set_kept,
   input  logic               req_set_has_mouths,
   input  logic [31:0]        req_set_rom_offset,
   input  logic [15:0]        req_set_bytes,
   // result channel
   output logic               rsp_strobe,
   output logic [2:0]         rsp_kind,
   output logic [3:0]         rsp_slot,
   output logic [8:0]         rsp_target_row,
   output logic               rsp_mouths_on,
   output logic [31:0]        rsp_load_offset,
   output logic [15:0]        rsp_load_bytes,
   output logic [4:0]         rsp_slots_in_use,
   output logic [31:0]        rsp_bytes_total,
   output logic [31:0]        rsp_overflow_count,
   output logic               rsp_overflow_notice,
   output logic               rsp_record_full,
   output logic               rsp_last,
   // configuration port
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   localparam int SW      = rspool_pkg::SCAN_W;
   localparam int UC_W    = $clog2(SLOT_COUNT + 1);
   localparam int RC_W    = $clog2(RECORD_DEPTH + 1);
   localparam int SLOT_AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int REC_AW  = (RECORD_DEPTH > 1) ? $clog2(RECORD_DEPTH) : 1;
   localparam logic [8:0]      SET_LIMIT = 9'(SET_COUNT);
   localparam logic [UC_W-1:0] SLOT_FULL = UC_W'(SLOT_COUNT);
   localparam logic [RC_W-1:0] REC_FULL  = RC_W'(RECORD_DEPTH);

   rspool_pkg::state_type state_ff, state_in;

   // Configuration and pool counters.
   logic [8:0]      row_limit_ff, row_limit_in;
   logic [UC_W-1:0] used_ff, used_in;
   logic [RC_W-1:0] rec_cnt_ff, rec_cnt_in;
   logic [31:0]     total_ff, total_in;
   logic [31:0]     missed_ff, missed_in;

   // Latched command payload and the slot outcome of the current ensure.
   logic [8:0]           row_ff, row_in;
   logic [8:0]           set_ff, set_in;
   logic                 mouths_ff, mouths_in;
   logic [31:0]          offset_ff, offset_in;
   logic [15:0]          nbytes_ff, nbytes_in;
   rspool_pkg::kind_type kind_ff, kind_in;
   logic [3:0]           slot_ff, slot_in;
   logic                 notice_ff, notice_in;

   // Result beat register.
   logic                 out_vld_ff, out_vld_in;
   rspool_pkg::kind_type out_kind_ff, out_kind_in;
   logic [3:0]           out_slot_ff, out_slot_in;
   logic [8:0]           out_row_ff, out_row_in;
   logic                 out_mouths_ff, out_mouths_in;
   logic [31:0]          out_off_ff, out_off_in;
   logic [15:0]          out_bytes_ff, out_bytes_in;
   logic [4:0]           out_used_ff, out_used_in;
   logic [31:0]          out_total_ff, out_total_in;
   logic [31:0]          out_missed_ff, out_missed_in;
   logic                 out_notice_ff, out_notice_in;
   logic                 out_full_ff, out_full_in;
   logic                 out_last_ff, out_last_in;

   logic accept;
   logic ignore;
   logic csr_wr;
   logic [31:0] missed_inc;

   rspool_pkg::scan_cmd_type  scan_cmd;
   rspool_pkg::scan_stat_type scan_stat;
   logic [8:0] scan_rd_data;

   logic               slot_wr_en;
   logic [SLOT_AW-1:0] slot_wr_addr;
   logic               slot_rd_en;
   logic [8:0]         slot_rd_data;
   logic               rec_wr_en;
   logic [REC_AW-1:0]  rec_wr_addr;
   logic [9:0]         rec_wr_data;
   logic               rec_rd_en;
   logic [9:0]         rec_rd_data;

   assign accept = start && (state_ff == rspool_pkg::ST_IDLE);
   assign busy   = (state_ff != rspool_pkg::ST_IDLE);
   assign csr_wr = psel && penable && pwrite;
   assign pready = 1'b1;
   assign prdata = (paddr[2] == rspool_pkg::CSR_ROW_LIMIT) ? {23'd0, row_limit_ff} : 32'd0;

   // A negative or out-of-range row or set, or a kept set, is left alone.
   assign ignore = req_row[9] || (req_row[8:0] >= row_limit_ff) ||
                   req_set_index[8] || (req_set_index[8:0] >= SET_LIMIT) ||
                   req_set_kept;

   assign missed_inc = missed_ff + 32'd1;

   // The single comparator sees slot owners in the slot scan and stored rows
   // otherwise.
   assign scan_rd_data = (state_ff == rspool_pkg::ST_SLOT_SCAN) ? slot_rd_data :
                                                                   rec_rd_data[8:0];

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rspool_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_operation == rspool_pkg::OP_RESET) begin
                  state_in = rspool_pkg::ST_DUMP;
               end else if (!ignore) begin
                  state_in = rspool_pkg::ST_SLOT_SCAN;
               end
            end
         end
         rspool_pkg::ST_SLOT_SCAN: begin
            if (scan_stat.done) begin
               state_in = rspool_pkg::ST_REC_SCAN;
            end
         end
         rspool_pkg::ST_REC_SCAN: begin
            if (scan_stat.done) begin
               state_in = rspool_pkg::ST_IDLE;
            end
         end
         rspool_pkg::ST_DUMP: begin
            if (scan_stat.done) begin
               state_in = rspool_pkg::ST_SUMMARY;
            end
         end
         rspool_pkg::ST_SUMMARY: begin
            state_in = rspool_pkg::ST_IDLE;
         end
         default: begin
            state_in = rspool_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath, scan commands, memory writes and result beats.
   always_comb begin
      row_limit_in = row_limit_ff;
      used_in      = used_ff;
      rec_cnt_in   = rec_cnt_ff;
      total_in     = total_ff;
      missed_in    = missed_ff;
      row_in       = row_ff;
      set_in       = set_ff;
      mouths_in    = mouths_ff;
      offset_in    = offset_ff;
      nbytes_in    = nbytes_ff;
      kind_in      = kind_ff;
      slot_in      = slot_ff;
      notice_in    = notice_ff;

      out_vld_in    = 1'b0;
      out_kind_in   = out_kind_ff;
      out_slot_in   = out_slot_ff;
      out_row_in    = out_row_ff;
      out_mouths_in = out_mouths_ff;
      out_off_in    = out_off_ff;
      out_bytes_in  = out_bytes_ff;
      out_used_in   = out_used_ff;
      out_total_in  = out_total_ff;
      out_missed_in = out_missed_ff;
      out_notice_in = out_notice_ff;
      out_full_in   = out_full_ff;
      out_last_in   = out_last_ff;

      scan_cmd.start = 1'b0;
      scan_cmd.walk  = 1'b0;
      scan_cmd.limit = '0;
      scan_cmd.key   = '0;

      slot_wr_en   = 1'b0;
      slot_wr_addr = SLOT_AW'(used_ff);
      rec_wr_en    = 1'b0;
      rec_wr_addr  = REC_AW'(rec_cnt_ff);
      rec_wr_data  = {mouths_ff, row_ff};

      slot_rd_en = scan_stat.rd_en && (state_ff == rspool_pkg::ST_SLOT_SCAN);
      rec_rd_en  = scan_stat.rd_en && ((state_ff == rspool_pkg::ST_REC_SCAN) ||
                                       (state_ff == rspool_pkg::ST_DUMP));

      if (csr_wr && (paddr[2] == rspool_pkg::CSR_ROW_LIMIT)) begin
         row_limit_in = pwdata[8:0];
      end

      unique case (state_ff)
         rspool_pkg::ST_IDLE: begin
            if (accept) begin
               row_in    = req_row[8:0];
               set_in    = req_set_index[8:0];
               mouths_in = req_set_has_mouths;
               offset_in = req_set_rom_offset;
               nbytes_in = req_set_bytes;
               if (req_operation == rspool_pkg::OP_RESET) begin
                  scan_cmd.start = 1'b1;
                  scan_cmd.walk  = 1'b1;
                  scan_cmd.limit = SW'(rec_cnt_ff);
               end else if (ignore) begin
                  out_vld_in    = 1'b1;
                  out_kind_in   = rspool_pkg::KIND_IGNORED;
                  out_slot_in   = '0;
                  out_row_in    = '0;
                  out_mouths_in = 1'b0;
                  out_off_in    = '0;
                  out_bytes_in  = '0;
                  out_used_in   = 5'(used_ff);
                  out_total_in  = total_ff;
                  out_missed_in = missed_ff;
                  out_notice_in = 1'b0;
                  out_full_in   = 1'b0;
                  out_last_in   = 1'b1;
               end else begin
                  scan_cmd.start = 1'b1;
                  scan_cmd.limit = SW'(used_ff);
                  scan_cmd.key   = req_set_index[8:0];
               end
            end
         end
         rspool_pkg::ST_SLOT_SCAN: begin
            if (scan_stat.done) begin
               notice_in = 1'b0;
               if (scan_stat.hit) begin
                  kind_in = rspool_pkg::KIND_HIT;
                  slot_in = 4'(scan_stat.index);
               end else if (used_ff == SLOT_FULL) begin
                  // The count just reached a power of two when the new value
                  // shares no set bit with the old one; zero after a wrap counts.
                  kind_in   = rspool_pkg::KIND_OVERFLOW;
                  slot_in   = '0;
                  missed_in = missed_inc;
                  notice_in = ((missed_inc & missed_ff) == 32'd0);
               end else begin
                  // Slots fill in order, so the free slot is the fill count.
                  kind_in    = rspool_pkg::KIND_LOAD;
                  slot_in    = 4'(used_ff);
                  slot_wr_en = 1'b1;
                  used_in    = used_ff + UC_W'(1);
                  total_in   = total_ff + {16'd0, nbytes_ff};
               end
               scan_cmd.start = 1'b1;
               scan_cmd.limit = SW'(rec_cnt_ff);
               scan_cmd.key   = row_ff;
            end
         end
         rspool_pkg::ST_REC_SCAN: begin
            if (scan_stat.done) begin
               out_full_in = 1'b0;
               if (scan_stat.hit) begin
                  // Known row: only its mouth flag is refreshed.
                  rec_wr_en   = 1'b1;
                  rec_wr_addr = REC_AW'(scan_stat.index);
               end else if (rec_cnt_ff < REC_FULL) begin
                  rec_wr_en  = 1'b1;
                  rec_cnt_in = rec_cnt_ff + RC_W'(1);
               end else begin
                  out_full_in = 1'b1;
               end
               out_vld_in    = 1'b1;
               out_kind_in   = kind_ff;
               out_slot_in   = slot_ff;
               out_row_in    = row_ff;
               out_mouths_in = mouths_ff;
               out_off_in    = (kind_ff == rspool_pkg::KIND_LOAD) ? offset_ff : 32'd0;
               out_bytes_in  = (kind_ff == rspool_pkg::KIND_LOAD) ? nbytes_ff : 16'd0;
               out_used_in   = 5'(used_ff);
               out_total_in  = total_ff;
               out_missed_in = missed_ff;
               out_notice_in = notice_ff;
               out_last_in   = 1'b1;
            end
         end
         rspool_pkg::ST_DUMP: begin
            if (scan_stat.chk_vld) begin
               out_vld_in    = 1'b1;
               out_kind_in   = rspool_pkg::KIND_BLANK_ROW;
               out_slot_in   = '0;
               out_row_in    = rec_rd_data[8:0];
               out_mouths_in = rec_rd_data[9];
               out_off_in    = '0;
               out_bytes_in  = '0;
               out_used_in   = 5'(used_ff);
               out_total_in  = total_ff;
               out_missed_in = missed_ff;
               out_notice_in = 1'b0;
               out_full_in   = 1'b0;
               out_last_in   = 1'b0;
            end
         end
         rspool_pkg::ST_SUMMARY: begin
            out_vld_in    = 1'b1;
            out_kind_in   = rspool_pkg::KIND_SUMMARY;
            out_slot_in   = '0;
            out_row_in    = '0;
            out_mouths_in = 1'b0;
            out_off_in    = '0;
            out_bytes_in  = '0;
            out_used_in   = 5'(used_ff);
            out_total_in  = total_ff;
            out_missed_in = missed_ff;
            out_notice_in = 1'b0;
            out_full_in   = 1'b0;
            out_last_in   = 1'b1;
            // The summary beat still carries the old counters; the new
            // generation starts empty.
            used_in    = '0;
            rec_cnt_in = '0;
            total_in   = '0;
            missed_in  = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rspool_pkg::ST_IDLE;
         row_limit_ff <= rspool_pkg::ROW_LIMIT_RESET;
         used_ff      <= '0;
         rec_cnt_ff   <= '0;
         total_ff     <= '0;
         missed_ff    <= '0;
         out_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_limit_ff <= row_limit_in;
         used_ff      <= used_in;
         rec_cnt_ff   <= rec_cnt_in;
         total_ff     <= total_in;
         missed_ff    <= missed_in;
         out_vld_ff   <= out_vld_in;
      end
      row_ff        <= row_in;
      set_ff        <= set_in;
      mouths_ff     <= mouths_in;
      offset_ff     <= offset_in;
      nbytes_ff     <= nbytes_in;
      kind_ff       <= kind_in;
      slot_ff       <= slot_in;
      notice_ff     <= notice_in;
      out_kind_ff   <= out_kind_in;
      out_slot_ff   <= out_slot_in;
      out_row_ff    <= out_row_in;
      out_mouths_ff <= out_mouths_in;
      out_off_ff    <= out_off_in;
      out_bytes_ff  <= out_bytes_in;
      out_used_ff   <= out_used_in;
      out_total_ff  <= out_total_in;
      out_missed_ff <= out_missed_in;
      out_notice_ff <= out_notice_in;
      out_full_ff   <= out_full_in;
      out_last_ff   <= out_last_in;
   end

   rspool_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .cmd     (scan_cmd),
      .rd_data (scan_rd_data),
      .stat    (scan_stat)
   );

   // Set index owned by each occupied slot.
   rspool_ram #(
      .WIDTH (9),
      .DEPTH (SLOT_COUNT)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_wr_en),
      .wr_addr (slot_wr_addr),
      .wr_data (set_ff),
      .rd_en   (slot_rd_en),
      .rd_addr (scan_stat.rd_addr[SLOT_AW-1:0]),
      .rd_data (slot_rd_data)
   );

   // Record list: row in the low nine bits, mouth flag on top.
   rspool_ram #(
      .WIDTH (10),
      .DEPTH (RECORD_DEPTH)
   ) u_rec_ram (
      .clock   (clock),
      .wr_en   (rec_wr_en),
      .wr_addr (rec_wr_addr),
      .wr_data (rec_wr_data),
      .rd_en   (rec_rd_en),
      .rd_addr (scan_stat.rd_addr[REC_AW-1:0]),
      .rd_data (rec_rd_data)
   );

   assign rsp_strobe          = out_vld_ff;
   assign rsp_kind            = out_kind_ff;
   assign rsp_slot            = out_slot_ff;
   assign rsp_target_row      = out_row_ff;
   assign rsp_mouths_on       = out_mouths_ff;
   assign rsp_load_offset     = out_off_ff;
   assign rsp_load_bytes      = out_bytes_ff;
   assign rsp_slots_in_use    = out_used_ff;
   assign rsp_bytes_total     = out_total_ff;
   assign rsp_overflow_count  = out_missed_ff;
   assign rsp_overflow_notice = out_notice_ff;
   assign rsp_record_full     = out_full_ff;
   assign rsp_last            = out_last_ff;

endmodule

FILE: rtl/rspool_checker.sv
`timescale 1ns / 1ps
`include "resident_slot_pool_no_evict_macros.svh"

module rspool_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input logic [2:0]  rsp_kind,
   input logic [3:0]  rsp_slot,
   input logic [8:0]  rsp_target_row,
   input logic        rsp_mouths_on,
   input logic [31:0] rsp_load_offset,
   input logic [15:0] rsp_load_bytes,
   input logic [31:0] rsp_overflow_count,
   input logic        rsp_overflow_notice,
   input logic        rsp_last
);

   // An accepted command either goes busy or answers at once.
   `RSPOOL_ASSERT_NEXT(a_accept_reacts, clock, reset, start && !busy, busy || rsp_strobe)

   // Only blank-row beats lack the last mark.
   `RSPOOL_ASSERT_IMPLY(a_last_mark, clock, reset, rsp_strobe, rsp_last == (rsp_kind != rspool_pkg::KIND_BLANK_ROW))

   // A notice means the count is zero or a single power of two.
   `RSPOOL_ASSERT_IMPLY(a_notice_pow2, clock, reset, rsp_strobe && rsp_overflow_notice, $countones(rsp_overflow_count) <= 1)

   // An ignored request carries no slot, row or load.
   `RSPOOL_ASSERT_IMPLY(a_ignored_empty, clock, reset, rsp_strobe && (rsp_kind == rspool_pkg::KIND_IGNORED), (rsp_slot == 4'd0) && (rsp_target_row == 9'd0) && !rsp_mouths_on && (rsp_load_offset == 32'd0) && (rsp_load_bytes == 16'd0))

endmodule

bind resident_slot_pool_no_evict rspool_checker u_rspool_checker (.*);
